// ----- sv/mce_pkg.sv -----
// shared types, constants and constant functions of the manning conductivity block
package mce_pkg;

    localparam int LOG_FRAC = 48;

    localparam logic [31:0] EXPONENT_RESET = 32'd178956971;
    localparam logic [47:0] EPSILON_RESET  = 48'd10995;

    // register select is paddr bit 3 (8-byte register spacing)
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_EPSILON  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef enum logic [1:0] {
        KIND_NORM,
        KIND_ZERO,
        KIND_DIV0,
        KIND_SAT
    } t_kind;

    typedef struct packed {
        logic signed [47:0] pressure;
        logic [47:0]        slope;
        logic [31:0]        manning_coef;
    } t_in_item;

    typedef struct packed {
        logic [63:0] conductivity;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic signed [6:0]  ip;
    } t_side;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_q;
        logic [63:0] rem;
        res   = '0;
        bit_q = 64'h4000_0000_0000_0000;
        rem   = v;
        for (int i = 0; i < 32; i++) begin
            if (bit_q > rem) bit_q = bit_q >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bit_q != 64'd0) begin
                if (rem >= res + bit_q) begin
                    rem = rem - (res + bit_q);
                    res = (res >> 1) + bit_q;
                end else begin
                    res = res >> 1;
                end
                bit_q = bit_q >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-k) in Q1.31, by repeated truncated square roots
    function automatic logic [32:0] exp_root(input int k);
        logic [63:0] root;
        root = 64'h1_0000_0000;
        for (int i = 1; i <= k; i++) begin
            root = isqrt64(root << 31);
        end
        return root[32:0];
    endfunction

endpackage

// ----- sv/mce_stream_if.sv -----
// valid/ready stream channel carrying one payload item
interface mce_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- sv/mce_log2_lane.sv -----
// pipelined base-2 logarithm: msb search, normalize, then one squaring per stage
module mce_log2_lane #(
    parameter int W    = 48,
    parameter int BIAS = 32,
    parameter int N    = 24
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [W-1:0]        i_v,
    output logic signed [55:0]  o_log
);
    logic [W-1:0]       r_a_v;
    logic [6:0]         r_a_msb;
    logic [6:0]         n_a_msb;
    logic [6:0]         w_sh;
    logic [W-1:0]       w_norm;
    logic [31:0]        r_m    [0:N];
    logic [47:0]        r_frac [0:N];
    logic [6:0]         r_msb  [0:N];
    logic signed [55:0] r_log;
    logic signed [55:0] n_log;

    always_comb begin
        n_a_msb = '0;
        for (int i = 0; i < W; i++) begin
            if (i_v[i]) n_a_msb = 7'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_v   <= i_v;
            r_a_msb <= n_a_msb;
        end
    end

    assign w_sh   = 7'(W - 1) - r_a_msb;
    assign w_norm = r_a_v << w_sh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]    <= w_norm[W-1 -: 32];
            r_frac[0] <= '0;
            r_msb[0]  <= r_a_msb;
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_sq
        logic [63:0] w_sq;
        logic [32:0] w_hi;
        assign w_sq = {32'b0, r_m[k-1]} * {32'b0, r_m[k-1]};
        assign w_hi = w_sq[63:31];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                // square at or above 2.0 yields a one bit and is halved
                if (w_hi[32]) begin
                    r_m[k]    <= w_hi[32:1];
                    r_frac[k] <= r_frac[k-1] | (48'd1 << (mce_pkg::LOG_FRAC - k));
                end else begin
                    r_m[k]    <= w_hi[31:0];
                    r_frac[k] <= r_frac[k-1];
                end
                r_msb[k] <= r_msb[k-1];
            end
        end
    end

    assign n_log = signed'((56'(r_msb[N]) - 56'(BIAS)) << mce_pkg::LOG_FRAC)
                 | signed'(56'(r_frac[N]));

    always_ff @(posedge i_clk) begin
        if (i_en) r_log <= n_log;
    end

    assign o_log = r_log;
endmodule

// ----- sv/mce_exp2_frac.sv -----
// pipelined 2^f for a 48-bit fraction: one constant root multiply per stage
module mce_exp2_frac #(
    parameter int N = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  mce_pkg::t_side   i_side,
    input  logic [47:0]      i_f,
    output mce_pkg::t_side   o_side,
    output logic [31:0]      o_acc
);
    logic [31:0]     r_acc  [0:N];
    logic [47:0]     r_f    [0:N];
    mce_pkg::t_side  r_side [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0] <= '0;
        end else if (i_en) begin
            r_side[0] <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0] <= 32'h8000_0000;
            r_f[0]   <= i_f;
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_mul
        localparam logic [32:0] ROOT = mce_pkg::exp_root(k);
        logic [64:0] w_prod;
        assign w_prod = {33'b0, r_acc[k-1]} * {32'b0, ROOT};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else if (i_en) begin
                r_side[k] <= r_side[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= r_f[k-1][mce_pkg::LOG_FRAC - k] ? w_prod[62:31] : r_acc[k-1];
                r_f[k]   <= r_f[k-1];
            end
        end
    end

    assign o_side = r_side[N];
    assign o_acc  = r_acc[N];
endmodule

// ----- sv/manning_conductivity_eval_core.sv -----
// manning conductivity top level: log lanes, exponent multiply, exp2 pipeline, output skid
//
//  channel  dir  handshake          payload
//  i_in     in   valid/ready        pressure, slope, manning_coef
//  o_out    out  valid/ready        conductivity, status
//  apb      in   psel/penable       manning_exponent @0x0, slope_epsilon @0x8
//
// one cell per cycle sustained while the skid stage is empty; the pipeline depth is
// set by N (POW_ITERATIONS capped at 48), the squaring stages of the log lanes and the root
// multiply stages of the exp2 unit
// synchronous active-low reset clears valid bits and restores register defaults
// a full skid stage freezes the pipeline; i_in.ready follows the skid being empty
module manning_conductivity_eval_core #(
    parameter int POW_ITERATIONS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mce_stream_if.sink          i_in,
    mce_stream_if.source        o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    localparam int N    = (POW_ITERATIONS > 48) ? 48 : POW_ITERATIONS;
    localparam int LLAT = N + 3;

    logic [31:0] r_exp;
    logic [47:0] r_eps;
    logic        w_en;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[3] == mce_pkg::REG_EPSILON) ? {16'b0, r_eps} : {32'b0, r_exp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= mce_pkg::EXPONENT_RESET;
            r_eps <= mce_pkg::EPSILON_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[3] == mce_pkg::REG_EXPONENT) r_exp <= pwdata[31:0];
            else                                    r_eps <= pwdata[47:0];
        end
    end

    // stage 0: input register and special-case classification
    logic [47:0]     w_s_cl;
    mce_pkg::t_kind  w_kind0;
    mce_pkg::t_side  r0_side;
    logic [47:0]     r0_p;
    logic [47:0]     r0_s;
    logic [31:0]     r0_c;

    assign i_in.ready = w_en;
    assign w_s_cl = (i_in.data.slope < r_eps) ? r_eps : i_in.data.slope;

    always_comb begin
        if (i_in.data.pressure == '0 || i_in.data.pressure[47]) begin
            w_kind0 = mce_pkg::KIND_ZERO;
        end else if (i_in.data.manning_coef == '0 || w_s_cl == '0) begin
            w_kind0 = mce_pkg::KIND_DIV0;
        end else begin
            w_kind0 = mce_pkg::KIND_NORM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_side <= '0;
        end else if (w_en) begin
            r0_side <= '{valid: i_in.valid, kind: w_kind0, ip: '0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_p <= i_in.data.pressure;
            r0_s <= w_s_cl;
            r0_c <= i_in.data.manning_coef;
        end
    end

    // log lanes
    logic signed [55:0] w_log_p;
    logic signed [55:0] w_log_s;
    logic signed [55:0] w_log_c;

    mce_log2_lane #(.W(48), .BIAS(32), .N(N)) u_log_p (
        .i_clk(i_clk), .i_en(w_en), .i_v(r0_p), .o_log(w_log_p)
    );
    mce_log2_lane #(.W(48), .BIAS(40), .N(N)) u_log_s (
        .i_clk(i_clk), .i_en(w_en), .i_v(r0_s), .o_log(w_log_s)
    );
    mce_log2_lane #(.W(32), .BIAS(24), .N(N)) u_log_c (
        .i_clk(i_clk), .i_en(w_en), .i_v(r0_c), .o_log(w_log_c)
    );

    mce_pkg::t_side r_sdl [0:LLAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LLAT; i++) r_sdl[i] <= '0;
        end else if (w_en) begin
            r_sdl[0] <= r0_side;
            for (int i = 1; i < LLAT; i++) r_sdl[i] <= r_sdl[i-1];
        end
    end

    // m1: magnitude of pressure log
    mce_pkg::t_side     r1_side;
    logic [55:0]        r1_mag;
    logic               r1_neg;
    logic signed [55:0] r1_lc;
    logic signed [55:0] r1_ls;

    // m2: split product with the exponent
    logic [32:0]        w_x;
    mce_pkg::t_side     r2_side;
    logic [60:0]        r2_ph;
    logic [60:0]        r2_pl;
    logic               r2_neg;
    logic signed [55:0] r2_lc;
    logic signed [55:0] r2_ls;

    // m3: recombine, halve slope log toward zero
    logic [60:0]        w_mag2;
    logic signed [55:0] w_lsr;
    mce_pkg::t_side     r3_side;
    logic signed [63:0] r3_lx;
    logic signed [55:0] r3_lc;
    logic signed [55:0] r3_lsh;

    // m4: exponent sum
    mce_pkg::t_side     r4_side;
    logic signed [63:0] r4_t;

    assign w_x    = {1'b0, r_exp} + 33'h1000_0000;
    assign w_mag2 = r2_ph + (r2_pl >> 28);
    assign w_lsr  = r2_ls + signed'({55'b0, r2_ls[55]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side <= '0;
            r2_side <= '0;
            r3_side <= '0;
            r4_side <= '0;
        end else if (w_en) begin
            r1_side <= r_sdl[LLAT-1];
            r2_side <= r1_side;
            r3_side <= r2_side;
            r4_side <= r3_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_neg <= w_log_p[55];
            r1_mag <= w_log_p[55] ? 56'(-w_log_p) : 56'(w_log_p);
            r1_lc  <= w_log_c;
            r1_ls  <= w_log_s;

            r2_ph  <= 61'(w_x) * 61'(r1_mag[55:28]);
            r2_pl  <= 61'(w_x) * 61'(r1_mag[27:0]);
            r2_neg <= r1_neg;
            r2_lc  <= r1_lc;
            r2_ls  <= r1_ls;

            r3_lx  <= r2_neg ? -signed'(64'(w_mag2)) : signed'(64'(w_mag2));
            r3_lc  <= r2_lc;
            r3_lsh <= w_lsr >>> 1;

            r4_t   <= r3_lx - 64'(r3_lc) - 64'(r3_lsh);
        end
    end

    // m5: integer/fraction split, overflow and underflow
    logic signed [15:0] w_ipf;
    mce_pkg::t_side     w5_side;

    assign w_ipf = r4_t[63:48];

    always_comb begin
        w5_side      = r4_side;
        w5_side.ip   = w_ipf[6:0];
        if (r4_side.kind == mce_pkg::KIND_NORM) begin
            if (w_ipf >= 16'sd32)       w5_side.kind = mce_pkg::KIND_SAT;
            else if (w_ipf < -16'sd33)  w5_side.kind = mce_pkg::KIND_ZERO;
        end
    end

    mce_pkg::t_side w_fin_side;
    logic [31:0]    w_acc;

    mce_exp2_frac #(.N(N)) u_exp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_side(w5_side), .i_f(r4_t[47:0]),
        .o_side(w_fin_side), .o_acc(w_acc)
    );

    // final scale and result select
    logic signed [7:0]   w_sh;
    logic [7:0]          w_nsh;
    logic [63:0]         w_scaled;
    mce_pkg::t_out_item  w_fin;

    assign w_sh  = signed'({w_fin_side.ip[6], w_fin_side.ip}) + 8'sd1;
    assign w_nsh = 8'(-w_sh);

    always_comb begin
        if (w_sh >= 8'sd0) w_scaled = {32'b0, w_acc} << w_sh[5:0];
        else               w_scaled = {32'b0, w_acc} >> w_nsh[5:0];
        unique case (w_fin_side.kind)
            mce_pkg::KIND_NORM: w_fin = '{conductivity: w_scaled, status: mce_pkg::ST_OK};
            mce_pkg::KIND_ZERO: w_fin = '{conductivity: '0, status: mce_pkg::ST_OK};
            mce_pkg::KIND_DIV0: w_fin = '{conductivity: '1, status: mce_pkg::ST_DIV0};
            mce_pkg::KIND_SAT:  w_fin = '{conductivity: '1, status: mce_pkg::ST_SAT};
            default:            w_fin = '{conductivity: '0, status: mce_pkg::ST_OK};
        endcase
    end

    // output register with skid stage
    logic                r_out_vld;
    mce_pkg::t_out_item  r_out;
    logic                r_skid_vld;
    mce_pkg::t_out_item  r_skid;

    assign w_en        = !r_skid_vld;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || o_out.ready) begin
            if (r_skid_vld) begin
                r_out      <= r_skid;
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else if (w_en && w_fin_side.valid) begin
                r_out     <= w_fin;
                r_out_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b0;
            end
        end else if (w_en && w_fin_side.valid) begin
            // output held: park the finished transfer
            r_skid     <= w_fin;
            r_skid_vld <= 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a transfer while output register is empty");

    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !o_out.ready) |=> (r_skid_vld && $stable(r_skid)))
        else $error("parked transfer lost or changed");

    a_div0_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status == mce_pkg::ST_DIV0)
            |-> (o_out.data.conductivity == '1))
        else $error("zero divisor result not all ones");

    a_sat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status == mce_pkg::ST_SAT)
            |-> (o_out.data.conductivity == '1))
        else $error("saturated result not all ones");
`endif

endmodule

// ----- sim/mce_tb_if.sv -----
// no testbench-side interfaces beyond the block's own stream channel
package mce_tb_types;
    typedef struct {
        logic [31:0] exponent;
        logic [47:0] epsilon;
    } t_cfg;
endpackage

// ----- sim/testbench.sv -----
// self-checking testbench of the manning conductivity block with a log-domain predictor
module testbench;

    localparam int    ITERS   = 24;
    localparam int    LATENCY = 2 * ITERS + 10;
    localparam longint LOG_ONE = 64'sd1 << 48;
    localparam int    LIMIT   = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    mce_stream_if #(.T(mce_pkg::t_in_item))  in_ch();
    mce_stream_if #(.T(mce_pkg::t_out_item)) out_ch();

    manning_conductivity_eval_core #(.POW_ITERATIONS(ITERS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    mce_tb_types::t_cfg  cfg;
    mce_pkg::t_in_item   pending_cells[$];
    mce_pkg::t_out_item  expected_cond[$];
    int        send_idle_pct = 0, recv_stall_pct = 0;
    int        mismatches = 0, cells_sent = 0, results_seen = 0, cycles = 0;
    int        sat_seen = 0, div0_seen = 0;

    // log2 with 48 fraction bits of a positive integer
    function automatic longint log2_fixed(input logic [63:0] v);
        int          msb;
        logic [63:0] m;
        logic [63:0] frac;
        msb  = 0;
        frac = '0;
        for (int b = 0; b < 64; b++) if (v[b]) msb = b;
        m = (msb >= 31) ? (v >> (msb - 31)) : (v << (31 - msb));
        for (int k = 1; k <= ITERS; k++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | (64'd1 << (48 - k));
                m = m >> 1;
            end
        end
        return longint'(msb) * LOG_ONE + longint'(frac);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, b;
        res = '0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] exp2_frac(input logic [63:0] f);
        logic [63:0] acc, root;
        acc  = 64'd1 << 31;
        root = 64'd1 << 32;
        for (int k = 1; k <= ITERS; k++) begin
            root = int_sqrt(root << 31);
            if (f[48 - k]) acc = (acc * root) >> 31;
        end
        return acc;
    endfunction

    function automatic mce_pkg::t_out_item conductivity_of(input mce_pkg::t_in_item c);
        mce_pkg::t_out_item r;
        logic [63:0] p, s, n, x, mag, bh, bl;
        longint      lp, lx, lc, ls, t, ip;
        int          sh;
        p = {16'd0, c.pressure};
        s = {16'd0, c.slope};
        n = {32'd0, c.manning_coef};
        r.conductivity = '0;
        r.status       = mce_pkg::ST_OK;
        if (s < {16'd0, cfg.epsilon}) s = {16'd0, cfg.epsilon};
        if (p == 0 || p[47]) return r;
        if (n == 0 || s == 0) begin
            r.conductivity = '1;
            r.status       = mce_pkg::ST_DIV0;
            return r;
        end
        x   = {32'd0, cfg.exponent} + (64'd1 << 28);
        lp  = log2_fixed(p) - 32 * LOG_ONE;
        mag = (lp < 0) ? 64'(-lp) : 64'(lp);
        bh  = mag >> 28;
        bl  = mag & ((64'd1 << 28) - 1);
        mag = x * bh + ((x * bl) >> 28);
        lx  = (lp < 0) ? -longint'(mag) : longint'(mag);
        lc  = log2_fixed(n) - 24 * LOG_ONE;
        ls  = log2_fixed(s) - 40 * LOG_ONE;
        t   = lx - lc - ls / 2;
        if (t >= 32 * LOG_ONE) begin
            r.conductivity = '1;
            r.status       = mce_pkg::ST_SAT;
            return r;
        end
        ip = t / LOG_ONE;
        if (t % LOG_ONE != 0 && t < 0) ip--;
        if (ip < -33) return r;
        sh = int'(ip) + 1;
        r.conductivity = (sh >= 0) ? (exp2_frac(64'(t - ip * LOG_ONE)) << sh)
                                   : (exp2_frac(64'(t - ip * LOG_ONE)) >> (-sh));
        return r;
    endfunction

    // driver: one nonblocking update of valid and data per edge
    always @(posedge i_clk) begin
        logic              fire, nv;
        mce_pkg::t_in_item nd;
        fire = in_ch.valid && in_ch.ready;
        nv   = in_ch.valid && !fire;
        nd   = in_ch.data;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (fire) begin
                expected_cond.push_back(conductivity_of(in_ch.data));
                cells_sent++;
            end
            if (!nv && pending_cells.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nv = 1'b1;
                nd = pending_cells.pop_front();
            end
        end
        in_ch.valid <= nv;
        in_ch.data  <= nd;
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        mce_pkg::t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (out_ch.data.status == mce_pkg::ST_SAT)  sat_seen++;
            if (out_ch.data.status == mce_pkg::ST_DIV0) div0_seen++;
            if (expected_cond.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: cond=%h status=%0d",
                             out_ch.data.conductivity, out_ch.data.status);
            end else begin
                want = expected_cond.pop_front();
                if (want.conductivity !== out_ch.data.conductivity ||
                    want.status !== out_ch.data.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected cond=%h status=%0d, got cond=%h status=%0d",
                                 want.conductivity, want.status,
                                 out_ch.data.conductivity, out_ch.data.status);
                end
            end
        end
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("manning_conductivity_eval_core test failed");
            $finish;
        end
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        cfg.exponent = mce_pkg::EXPONENT_RESET;
        cfg.epsilon  = mce_pkg::EPSILON_RESET;
    end

    task automatic write_reg(input logic sel, input logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == mce_pkg::REG_EXPONENT) cfg.exponent = val[31:0];
        else                              cfg.epsilon  = val[47:0];
    endtask

    task automatic drain();
        while (pending_cells.size() > 0 || in_ch.valid || expected_cond.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_bits(input int width);
        logic [63:0] v;
        int          w;
        v = {$urandom, $urandom};
        w = $urandom_range(width, 1);
        return (w >= 64) ? v : (v & ((64'd1 << w) - 1));
    endfunction

    function automatic mce_pkg::t_in_item rand_cell();
        mce_pkg::t_in_item c;
        int                mode;
        mode = $urandom_range(9);
        c.pressure     = 48'(rand_bits(47));
        c.slope        = 48'(rand_bits(48));
        c.manning_coef = 32'(rand_bits(32));
        if (mode == 0) c.pressure = -c.pressure;
        if (mode == 1) begin
            c.pressure     = 48'({$urandom, $urandom});
            c.slope        = 48'({$urandom, $urandom});
            c.manning_coef = $urandom;
        end
        if (mode == 2) c.manning_coef = '0;
        // keep half of the cells near unity so the exp2 path is exercised
        if (mode >= 5) begin
            c.pressure     = 48'($urandom & 32'hFFFF) << $urandom_range(32, 16);
            c.slope        = 48'({$urandom, $urandom} >> $urandom_range(40, 20));
            c.manning_coef = ($urandom & 32'hFFFFFF) | 32'h1000;
        end
        return c;
    endfunction

    function automatic mce_pkg::t_in_item mk(input logic [47:0] p, input logic [47:0] s,
                                             input logic [31:0] n);
        mce_pkg::t_in_item c;
        c.pressure     = p;
        c.slope        = s;
        c.manning_coef = n;
        return c;
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cells at reset configuration
        pending_cells.push_back(mk(48'd0, 48'd1 << 40, 32'd1 << 24));
        pending_cells.push_back(mk(48'hFFFF_FFFF_FFFF, 48'd1 << 40, 32'd1 << 24));
        pending_cells.push_back(mk(48'h8000_0000_0000, 48'd1 << 40, 32'd0));
        pending_cells.push_back(mk(48'd1 << 32, 48'd1 << 40, 32'd1 << 24));
        pending_cells.push_back(mk(48'd1 << 32, 48'd1 << 40, 32'd0));
        pending_cells.push_back(mk(48'h7FFF_FFFF_FFFF, 48'd0, 32'd1));
        pending_cells.push_back(mk(48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        pending_cells.push_back(mk(48'd1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        pending_cells.push_back(mk(48'd1, 48'd0, 32'd1));
        pending_cells.push_back(mk(48'd3 << 31, 48'd5 << 37, 32'd3 << 22));
        pending_cells.push_back(mk(48'h1234_5678_9ABC, 48'h0000_0001_0000, 32'h0100_0000));
        drain();

        // zero exponent, zero clamp: zero slope now divides by zero
        write_reg(mce_pkg::REG_EXPONENT, 64'd0);
        write_reg(mce_pkg::REG_EPSILON, 64'd0);
        pending_cells.push_back(mk(48'd1 << 32, 48'd0, 32'd1 << 24));
        pending_cells.push_back(mk(48'd5 << 30, 48'd1 << 38, 32'd1 << 24));
        pending_cells.push_back(mk(-48'sd5, 48'd0, 32'd0));
        drain();

        // largest exponent and clamp
        write_reg(mce_pkg::REG_EXPONENT, 64'hFFFF_FFFF);
        write_reg(mce_pkg::REG_EPSILON, 64'hFFFF_FFFF_FFFF);
        pending_cells.push_back(mk(48'd1 << 32, 48'd0, 32'd1 << 24));
        pending_cells.push_back(mk(48'd1 << 20, 48'd7, 32'hFFFF_FFFF));
        pending_cells.push_back(mk(48'h7FFF_FFFF_FFFF, 48'd1, 32'd1));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            case (ph)
                0: begin write_reg(mce_pkg::REG_EXPONENT, 64'(mce_pkg::EXPONENT_RESET));
                         write_reg(mce_pkg::REG_EPSILON, 64'(mce_pkg::EPSILON_RESET)); end
                1: begin write_reg(mce_pkg::REG_EXPONENT, 64'($urandom));
                         write_reg(mce_pkg::REG_EPSILON, rand_bits(48)); end
                2: begin write_reg(mce_pkg::REG_EXPONENT, 64'd1 << 28);
                         write_reg(mce_pkg::REG_EPSILON, 64'd1); end
                default: begin
                    write_reg(mce_pkg::REG_EXPONENT, 64'($urandom_range(32'h3000_0000)));
                    write_reg(mce_pkg::REG_EPSILON, rand_bits(30));
                end
            endcase
            for (int i = 0; i < 180; i++) pending_cells.push_back(rand_cell());
            // sender holds off until every result of the first half is back
            drain();
            for (int i = 0; i < 180; i++) pending_cells.push_back(rand_cell());
            drain();
        end

        $display("covered %0d cells over %0d register settings and four handshake mixes",
                 cells_sent, 7);
        $display("%0d results checked, %0d saturated, %0d zero divisor",
                 results_seen, sat_seen, div0_seen);
        if (mismatches == 0 && expected_cond.size() == 0)
            $display("manning_conductivity_eval_core test passed");
        else
            $display("manning_conductivity_eval_core test failed");
        $finish;
    end
endmodule
